// ----- rtl/tedt_pkg.sv -----
`default_nettype none

package tedt_pkg;

  // table size and its split over the cell chain
  localparam int unsigned MAX_EDGES  = 4096;
  localparam int unsigned NUM_CELLS  = 4;
  localparam int unsigned SEL_W      = $clog2(NUM_CELLS);
  localparam int unsigned BANK_DEPTH = (MAX_EDGES + NUM_CELLS - 1) / NUM_CELLS;
  localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_EDGES + 1);

  localparam int unsigned VTX_W   = 16;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned ENTRY_W = 2 * VTX_W;

  typedef struct packed {
    logic             start_mesh;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    logic [VTX_W-1:0] vertex_c;
  } triangle_t;

  typedef struct packed {
    logic [VTX_W-1:0]   edge_from;
    logic [VTX_W-1:0]   edge_to;
    logic               is_new;
    logic               table_full;
    logic [TOTAL_W-1:0] edge_total;
    logic               last_edge;
  } result_t;

  // search token walking down the cell chain, one table row per token
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [ENTRY_W-1:0]   fwd;
    logic [ENTRY_W-1:0]   rev;
    logic [NUM_CELLS-1:0] mask;
    logic                 hit;
  } scan_tok_t;

endpackage

`default_nettype wire

// ----- rtl/tedt_in_if.sv -----
`default_nettype none

interface tedt_in_if import tedt_pkg::*; ();
  logic      valid;
  logic      ready;
  triangle_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tedt_out_if.sv -----
`default_nettype none

interface tedt_out_if import tedt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tedt_cell.sv -----
`default_nettype none

module tedt_cell import tedt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scan_tok_t          tok_i,
  output scan_tok_t               tok_o,
  input  wire logic               wr_en_i,
  input  wire logic [ROW_W-1:0]   wr_row_i,
  input  wire logic [ENTRY_W-1:0] wr_data_i
);

  // one bank of the edge table: entries whose index mod NUM_CELLS is this cell
  logic [ENTRY_W-1:0] mem_q [BANK_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  scan_tok_t          tok_q;
  logic               vld_q;
  logic               match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    rd_q  <= mem_q[tok_i.row];
    tok_q <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  // lowest mask bit belongs to this cell, the rest shift on to the neighbor
  assign match = tok_q.mask[0] && ((rd_q == tok_q.fwd) || (rd_q == tok_q.rev));

  always_comb begin
    tok_o      = tok_q;
    tok_o.vld  = vld_q;
    tok_o.mask = tok_q.mask >> 1;
    tok_o.hit  = tok_q.hit | (vld_q & match);
  end

endmodule

`default_nettype wire

// ----- rtl/triangle_edge_dedup_table_top.sv -----
`default_nettype none

// channel | dir | transaction carries
// --------+-----+-----------------------------------------------------------
// face_i  | in  | one triangle: start_mesh, vertex_a, vertex_b, vertex_c
// res_o   | out | one edge result: edge_from, edge_to, is_new, table_full,
//         |     | edge_total, last_edge (three per triangle)
//
// each edge scans the table one row per cycle, a row being NUM_CELLS entries
// held side by side in the cell chain; the edge then waits in drain until the
// last row's token leaves the tail cell (an empty table skips the scan)
// reset clears the edge count and all control; table contents are not cleared
// a new triangle is taken while the previous last result still waits at res_o;
// a stalled res_o holds the block only when the next result is ready to leave

module triangle_edge_dedup_table_top import tedt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tedt_in_if.sink    face_i,
  tedt_out_if.source res_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_DRAIN   = 2'd2;
  localparam logic [1:0] S_RESOLVE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       eidx_q, eidx_d;
  logic             hit_q, hit_d;
  logic [VTX_W-1:0] va_q, vb_q, vc_q;

  result_t res_q, res_d;
  logic    res_vld_q, res_vld_d;
  logic    res_load;

  // current edge as formed from the triangle: a-b, b-c, c-a
  logic [VTX_W-1:0] e_from, e_to;
  logic [ROW_W-1:0] last_row;
  logic             tbl_has_room;

  // cell chain
  scan_tok_t                chain [NUM_CELLS+1];
  logic                     wr_en;
  logic [ROW_W-1:0]         wr_row;
  logic [SEL_W-1:0]         wr_sel;
  logic [NUM_CELLS-1:0]     wr_en_cell;

  always_comb begin
    unique case (eidx_q)
      2'd0: begin
        e_from = va_q;
        e_to   = vb_q;
      end
      2'd1: begin
        e_from = vb_q;
        e_to   = vc_q;
      end
      default: begin
        e_from = vc_q;
        e_to   = va_q;
      end
    endcase
  end

  assign last_row     = ROW_W'((cnt_q - CNT_W'(1)) >> SEL_W);
  assign tbl_has_room = cnt_q < CNT_W'(MAX_EDGES);

  // token into the head of the chain, one table row per cycle while scanning
  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = (state_q == S_SCAN) && (cnt_q != '0);
    chain[0].last = (row_q == last_row);
    chain[0].row  = row_q;
    chain[0].fwd  = {e_to, e_from};
    chain[0].rev  = {e_from, e_to};
    chain[0].hit  = 1'b0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      // entry row*NUM_CELLS+k is live only below the edge count
      chain[0].mask[k] = ((CNT_W'(row_q) << SEL_W) | CNT_W'(k)) < cnt_q;
    end
  end

  // new edges go to the bank and row picked by the current count
  assign wr_row = ROW_W'(cnt_q >> SEL_W);
  assign wr_sel = cnt_q[SEL_W-1:0];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    assign wr_en_cell[g] = wr_en && (wr_sel == SEL_W'(g));

    tedt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1]),
      .wr_en_i   (wr_en_cell[g]),
      .wr_row_i  (wr_row),
      .wr_data_i ({e_to, e_from})
    );
  end

  assign face_i.ready  = (state_q == S_IDLE);
  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    eidx_d    = eidx_q;
    hit_d     = hit_q;
    res_d     = res_q;
    res_load  = 1'b0;
    wr_en     = 1'b0;

    // collect row hits as they fall out of the tail cell
    if (chain[NUM_CELLS].vld) begin
      hit_d = hit_q | chain[NUM_CELLS].hit;
    end

    unique case (state_q)
      S_IDLE: begin
        if (face_i.valid) begin
          if (face_i.payload.start_mesh) begin
            cnt_d = '0;
          end
          row_d   = '0;
          eidx_d  = 2'd0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // empty table: nothing to look at
        if (cnt_q == '0) begin
          state_d = S_RESOLVE;
        end else if (row_q == last_row) begin
          state_d = S_DRAIN;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      S_DRAIN: begin
        if (chain[NUM_CELLS].vld && chain[NUM_CELLS].last) begin
          state_d = S_RESOLVE;
        end
      end
      default: begin
        // wait here only if the previous result is still unclaimed
        if (!res_vld_q || res_o.ready) begin
          res_load            = 1'b1;
          res_d.edge_from     = e_from;
          res_d.edge_to       = e_to;
          res_d.is_new        = 1'b0;
          res_d.table_full    = 1'b0;
          res_d.last_edge     = (eidx_q == 2'd2);
          if (!hit_q) begin
            if (tbl_has_room) begin
              wr_en        = 1'b1;
              cnt_d        = cnt_q + CNT_W'(1);
              res_d.is_new = 1'b1;
            end else begin
              res_d.table_full = 1'b1;
            end
          end
          res_d.edge_total = TOTAL_W'(cnt_d);
          row_d            = '0;
          hit_d            = 1'b0;
          if (eidx_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            eidx_d  = eidx_q + 2'd1;
            state_d = S_SCAN;
          end
        end
      end
    endcase

    res_vld_d = res_load | (res_vld_q & ~res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      row_q     <= '0;
      eidx_q    <= 2'd0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      eidx_q    <= eidx_d;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (face_i.valid && face_i.ready) begin
      va_q <= face_i.payload.vertex_a;
      vb_q <= face_i.payload.vertex_b;
      vc_q <= face_i.payload.vertex_c;
    end
    res_q <= res_d;
  end

endmodule

`default_nettype wire

// ----- dv/edge_dedup_checker.sv -----
`default_nettype none

module edge_dedup_checker import tedt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tedt_in_if          face_i,
  tedt_out_if         res_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned new_edges_o,
  output int unsigned dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // edges held by the block, keyed as {to, from} in the direction first stored
  bit          known_edges [bit [ENTRY_W-1:0]];
  int unsigned stored_edges = 0;
  // expected results in arrival order, read at exp_head and written at exp_tail
  result_t     expected_edges [int unsigned];
  int unsigned exp_head = 0;
  int unsigned exp_tail = 0;

  int unsigned mismatches   = 0;
  int unsigned outstanding  = 0;
  int unsigned checked      = 0;
  int unsigned fresh_edges  = 0;
  int unsigned dropped      = 0;

  assign errors_o    = mismatches;
  assign pending_o   = outstanding;
  assign results_o   = checked;
  assign new_edges_o = fresh_edges;
  assign dropped_o   = dropped;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // lookup in either direction, append when absent and room is left
  function automatic result_t classify_edge(input logic [VTX_W-1:0] from,
                                            input logic [VTX_W-1:0] to,
                                            input logic last);
    result_t r;
    logic [ENTRY_W-1:0] fwd;
    logic [ENTRY_W-1:0] rev;
    fwd          = {to, from};
    rev          = {from, to};
    r.edge_from  = from;
    r.edge_to    = to;
    r.is_new     = 1'b0;
    r.table_full = 1'b0;
    r.last_edge  = last;
    if (!(known_edges.exists(fwd) || known_edges.exists(rev))) begin
      if (stored_edges < MAX_EDGES) begin
        known_edges[fwd] = 1'b1;
        stored_edges++;
        r.is_new = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    r.edge_total = TOTAL_W'(stored_edges);
    return r;
  endfunction

  task automatic add_expected(input result_t r);
    expected_edges[exp_tail] = r;
    exp_tail++;
  endtask

  task automatic predict_triangle(input triangle_t t);
    if (t.start_mesh) begin
      known_edges.delete();
      stored_edges = 0;
    end
    add_expected(classify_edge(t.vertex_a, t.vertex_b, 1'b0));
    add_expected(classify_edge(t.vertex_b, t.vertex_c, 1'b0));
    add_expected(classify_edge(t.vertex_c, t.vertex_a, 1'b1));
  endtask

  task automatic check_field(input string name, input logic [VTX_W-1:0] got,
                             input logic [VTX_W-1:0] want, input result_t exp);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h on edge %0d-%0d",
                                name, got, want, exp.edge_from, exp.edge_to));
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (exp_head == exp_tail) begin
      report_mismatch($sformatf("edge result %0d-%0d with no triangle pending",
                                got.edge_from, got.edge_to));
    end else begin
      want = expected_edges[exp_head];
      expected_edges.delete(exp_head);
      exp_head++;
      check_field("edge_from", got.edge_from, want.edge_from, want);
      check_field("edge_to", got.edge_to, want.edge_to, want);
      check_field("is_new", VTX_W'(got.is_new), VTX_W'(want.is_new), want);
      check_field("table_full", VTX_W'(got.table_full), VTX_W'(want.table_full), want);
      check_field("edge_total", VTX_W'(got.edge_total), VTX_W'(want.edge_total), want);
      check_field("last_edge", VTX_W'(got.last_edge), VTX_W'(want.last_edge), want);
      checked++;
      if (want.is_new) fresh_edges++;
      if (want.table_full) dropped++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_edges.delete();
      stored_edges = 0;
      expected_edges.delete();
      exp_head = 0;
      exp_tail = 0;
    end else begin
      if (face_i.valid && face_i.ready) predict_triangle(face_i.payload);
      if (res_i.valid && res_i.ready) compare_result(res_i.payload);
    end
    outstanding = exp_tail - exp_head;
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tedt_pkg::*;

  // rough count of random triangles after the directed part
  localparam int unsigned RANDOM_TRIANGLES = 116;
  // at most ~450 stored edges: ~115 rows per edge scan; the limit is the expected
  // length of a run with stalls, taken several times over
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tedt_in_if  face_if ();
  tedt_out_if res_if ();

  triangle_edge_dedup_table_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .face_i (face_if),
    .res_o  (res_if)
  );

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned new_edges;
  int unsigned dropped_edges;

  // watches both channels, predicts every edge result and compares
  edge_dedup_checker edge_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .face_i      (face_if),
    .res_i       (res_if),
    .errors_o    (mismatches),
    .pending_o   (pending),
    .results_o   (results_seen),
    .new_edges_o (new_edges),
    .dropped_o   (dropped_edges)
  );

  always #6 clk_i = ~clk_i;

  // watchdog on the whole run
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d edge results still pending",
               cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // when set, neither side inserts bubbles
  bit          calm = 1'b0;
  int unsigned triangles_sent = 0;

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(16, 0);
  endfunction

  // one triangle transaction; valid stays high when no gap is drawn so that
  // it is never lowered and raised in the same step
  task automatic send_triangle(input logic start, input logic [VTX_W-1:0] a,
                               input logic [VTX_W-1:0] b, input logic [VTX_W-1:0] c);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      face_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    face_if.valid   <= 1'b1;
    face_if.payload <= '{start_mesh: start, vertex_a: a, vertex_b: b, vertex_c: c};
    @(posedge clk_i);
    while (!face_if.ready) @(posedge clk_i);
    triangles_sent++;
  endtask

  // hold the sender until every predicted edge result has come back
  task automatic wait_drained();
    face_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // well-formed mesh: a small vertex pool so edges recur, mostly walked as a
  // strip where each triangle reuses the previous one's middle edge reversed
  task automatic send_mesh();
    int unsigned      tris;
    int unsigned      pool;
    logic [VTX_W-1:0] base;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] c;
    tris = $urandom_range(12, 2);
    pool = $urandom_range(8, 3);
    base = VTX_W'($urandom);
    a    = base;
    b    = base + 16'd1;
    c    = base + 16'd2;
    for (int unsigned i = 0; i < tris; i++) begin
      if (i != 0) begin
        if ($urandom_range(2, 0) != 0) begin
          {a, c} = {c, base + VTX_W'($urandom_range(pool - 1, 0))};
        end else begin
          a = base + VTX_W'($urandom_range(pool - 1, 0));
          b = base + VTX_W'($urandom_range(pool - 1, 0));
          c = base + VTX_W'($urandom_range(pool - 1, 0));
        end
      end
      send_triangle(i == 0, a, b, c);
    end
  endtask

  // result side: a fresh stall drawn for every edge result
  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] c;
    face_if.valid   <= 1'b0;
    face_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate edges, extremes, reverse matches, in-triangle reuse
    send_triangle(1'b1, 16'd0, 16'd0, 16'd0);             // self edge, then twice seen
    send_triangle(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_triangle(1'b0, 16'd0, 16'hFFFF, 16'd0);          // middle edge matches the first one reversed
    send_triangle(1'b1, 16'd1, 16'd2, 16'd3);             // restart, three new edges
    send_triangle(1'b0, 16'd3, 16'd2, 16'd1);             // all reversed, all known
    send_triangle(1'b0, 16'd1, 16'd2, 16'd3);             // all forward, all known
    send_triangle(1'b0, 16'd2, 16'd1, 16'd4);             // one shared, two new
    send_triangle(1'b0, 16'd5, 16'd5, 16'd6);             // last edge added by the middle one
    send_triangle(1'b0, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_triangle(1'b0, 16'h5555, 16'hAAAA, 16'h0000);
    send_triangle(1'b1, 16'd1, 16'd2, 16'd3);             // new again after restart
    send_triangle(1'b1, 16'h8000, 16'h0001, 16'h7FFF);    // back to back restarts
    send_triangle(1'b0, 16'd0, 16'hFFFF, 16'h8000);
    send_triangle(1'b0, 16'h7FFF, 16'h0001, 16'h8000);

    // sender holds off until the block has emptied
    wait_drained();

    // random: mostly well-formed meshes, some noise triangles
    while (triangles_sent < 14 + RANDOM_TRIANGLES) begin
      calm = ($urandom_range(4, 0) == 0);
      if ($urandom_range(9, 0) < 7) begin
        send_mesh();
      end else begin
        a = VTX_W'($urandom);
        b = VTX_W'($urandom);
        c = VTX_W'($urandom);
        send_triangle(1'($urandom), a, b, c);
        if ($urandom_range(1, 0) == 0) send_triangle(1'b0, c, b, a);
      end
    end
    wait_drained();

    // a restart after the random part, then one shared edge
    calm = 1'b0;
    send_triangle(1'b1, 16'd1, 16'd2, 16'd3);
    send_triangle(1'b0, 16'd3, 16'd2, 16'd7);

    // let the last results out and watch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d triangles sent, %0d edge results checked", triangles_sent, results_seen);
    $display("%0d edges stored, %0d dropped on a full table, %0d mismatches",
             new_edges, dropped_edges, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
